@@ design/fcpq_pkg.sv @@
`timescale 1ns / 1ps
package fcpq_pkg;
	localparam int CAPACITY_DEF = 16;
	localparam int ID_WIDTH_DEF = 16;
	localparam int WAIT_W = 16;
	localparam int CLASS_W = 2;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SERVE  = 1'b1
	} op_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] client_id;
		logic [1:0]  priority_req;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] served_id;
		logic [1:0]  served_priority;
		logic [15:0] served_wait;
		logic [15:0] operation_count;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_PLACE,
		S_SRV_RD,
		S_SRV_CHK,
		S_SH_RD,
		S_SH_WR,
		S_AGE_RD,
		S_AGE_WR,
		S_DONE
	} fsm_t;
endpackage

@@ design/fcpq_ram.sv @@
`timescale 1ns / 1ps
module fcpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ design/four_class_priority_queue_top.sv @@
`timescale 1ns / 1ps
// four-class priority queue, command in / one result out per command
// in channel: in_valid/in_ready carrying in_item (operation, client_id, priority_req)
// out channel: out_valid/out_ready carrying out_item (status, ids, wait, op count)
// one command at a time: the queue is kept as a position-ordered list in one
// RAM (id, class, wait per position) with a registered read, each read used
// in the cycle after it is issued.
// a full insert or an empty serve raises out_valid the cycle after it is taken.
// an insert walks down from the tail moving lower classes up, places the entry
// and then, unless the queue was empty, ages the whole list.
// a serve scans from the head for the first entry at or below the level (the
// head if none), shifts the tail down and ages the rest.
// the result sits in an output register; if the receiver stalls it holds and
// no new command is taken until it is delivered.
// reset empties the queue and sets the operation count to one; RAM contents
// need no clearing since positions beyond occupancy are never used.
module four_class_priority_queue_top #(
	parameter int CAPACITY = fcpq_pkg::CAPACITY_DEF,
	parameter int ID_WIDTH = fcpq_pkg::ID_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fcpq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output fcpq_pkg::out_item_t out_item
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = fcpq_pkg::WAIT_W;
	localparam int KW = fcpq_pkg::CLASS_W;
	localparam int EW = ID_WIDTH + KW + WW;
	localparam logic [WW-1:0] SAT = '1;

	fcpq_pkg::fsm_t state_q, state_d;
	logic [CW-1:0] occ_q, p_q, p_dec, p_inc;
	logic [15:0] opc_q;
	logic op_q, cnt_q;
	logic [KW-1:0] cls_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [EW-1:0] carry_q;
	fcpq_pkg::out_item_t res_q;
	logic out_valid_q;
	logic accept;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	logic [ID_WIDTH-1:0] r_id;
	logic [KW-1:0] r_cls;
	logic [WW-1:0] r_wait, r_wait_inc;

	fcpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign r_id = rdata[EW-1 -: ID_WIDTH];
	assign r_cls = rdata[WW +: KW];
	assign r_wait = rdata[WW-1:0];
	assign r_wait_inc = (r_wait == SAT) ? r_wait : r_wait + 1'b1;

	assign p_dec = p_q - 1'b1;
	assign p_inc = p_q + 1'b1;

	assign in_ready = (state_q == fcpq_pkg::S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item = res_q;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fcpq_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// p_q is the hole position on insert, the scan/shift/age position otherwise
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = p_q[AW-1:0];
		wdata = rdata;
		raddr = p_q[AW-1:0];
		unique case (state_q)
			fcpq_pkg::S_IDLE: begin
				if (accept) begin
					if (in_item.operation == fcpq_pkg::OP_INSERT) begin
						if (occ_q < CW'(CAPACITY))
							state_d = fcpq_pkg::S_INS_RD;
					end else if (occ_q != '0)
						state_d = fcpq_pkg::S_SRV_RD;
				end
			end
			fcpq_pkg::S_INS_RD: begin
				raddr = p_dec[AW-1:0];
				state_d = (p_q == '0) ? fcpq_pkg::S_PLACE : fcpq_pkg::S_INS_CHK;
			end
			fcpq_pkg::S_INS_CHK: begin
				// lower class moves up into the hole
				if (r_cls < cls_q) begin
					we = 1'b1;
					state_d = fcpq_pkg::S_INS_RD;
				end else
					state_d = fcpq_pkg::S_PLACE;
			end
			fcpq_pkg::S_PLACE: begin
				we = 1'b1;
				wdata = {id_q, cls_q, {WW{1'b0}}};
				state_d = cnt_q ? fcpq_pkg::S_AGE_RD : fcpq_pkg::S_DONE;
			end
			fcpq_pkg::S_SRV_RD: state_d = fcpq_pkg::S_SRV_CHK;
			fcpq_pkg::S_SRV_CHK: begin
				if (r_cls <= cls_q || p_inc == occ_q)
					state_d = fcpq_pkg::S_SH_RD;
				else
					state_d = fcpq_pkg::S_SRV_RD;
			end
			fcpq_pkg::S_SH_RD:
				state_d = (p_q == occ_q) ? fcpq_pkg::S_AGE_RD : fcpq_pkg::S_SH_WR;
			fcpq_pkg::S_SH_WR: begin
				we = 1'b1;
				waddr = p_dec[AW-1:0];
				state_d = fcpq_pkg::S_SH_RD;
			end
			fcpq_pkg::S_AGE_RD:
				state_d = (p_q == occ_q) ? fcpq_pkg::S_DONE : fcpq_pkg::S_AGE_WR;
			fcpq_pkg::S_AGE_WR: begin
				we = 1'b1;
				wdata = {r_id, r_cls, r_wait_inc};
				state_d = fcpq_pkg::S_AGE_RD;
			end
			fcpq_pkg::S_DONE: state_d = fcpq_pkg::S_IDLE;
			default: state_d = fcpq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			opc_q <= 16'd1;
			out_valid_q <= 1'b0;
			p_q <= '0;
			op_q <= 1'b0;
			cnt_q <= 1'b0;
			cls_q <= '0;
			id_q <= '0;
			carry_q <= '0;
			res_q <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				fcpq_pkg::S_IDLE: if (accept) begin
					op_q <= in_item.operation;
					cls_q <= in_item.priority_req;
					id_q <= ID_WIDTH'(in_item.client_id);
					cnt_q <= (occ_q != '0);
					res_q.served_id <= '0;
					res_q.served_priority <= '0;
					res_q.served_wait <= '0;
					res_q.operation_count <= opc_q;
					if (in_item.operation == fcpq_pkg::OP_INSERT) begin
						if (occ_q < CW'(CAPACITY)) begin
							res_q.status <= fcpq_pkg::ST_INSERTED;
							p_q <= occ_q;
						end else begin
							res_q.status <= fcpq_pkg::ST_FULL;
							out_valid_q <= 1'b1;
						end
					end else begin
						if (occ_q != '0) begin
							res_q.status <= fcpq_pkg::ST_SERVED;
							p_q <= '0;
						end else begin
							res_q.status <= fcpq_pkg::ST_EMPTY;
							out_valid_q <= 1'b1;
						end
					end
				end
				fcpq_pkg::S_INS_CHK: if (r_cls < cls_q) p_q <= p_dec;
				fcpq_pkg::S_PLACE: begin
					occ_q <= occ_q + 1'b1;
					p_q <= '0;
				end
				fcpq_pkg::S_SRV_CHK: begin
					// the head is kept as the fallback when nothing matches
					if (p_q == '0 || r_cls <= cls_q)
						carry_q <= rdata;
					if (r_cls > cls_q && p_inc == occ_q)
						p_q <= CW'(1);
					else
						p_q <= p_inc;
				end
				fcpq_pkg::S_SH_RD: if (p_q == occ_q) begin
					occ_q <= occ_q - 1'b1;
					p_q <= '0;
				end
				fcpq_pkg::S_SH_WR: p_q <= p_inc;
				fcpq_pkg::S_AGE_WR: p_q <= p_inc;
				fcpq_pkg::S_DONE: begin
					if (op_q == fcpq_pkg::OP_SERVE) begin
						res_q.served_id <= 16'(carry_q[EW-1 -: ID_WIDTH]);
						res_q.served_priority <= carry_q[WW +: KW];
						res_q.served_wait <= carry_q[WW-1:0];
					end
					if (cnt_q && opc_q != 16'hFFFF) begin
						opc_q <= opc_q + 1'b1;
						res_q.operation_count <= opc_q + 1'b1;
					end
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready) else $error("command taken while result pending");
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY)) else $error("occupancy overflow");
	a_opc_mono: assert property (@(posedge clk) disable iff (!arst_n)
		opc_q >= $past(opc_q)) else $error("op count decreased");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("result changed while stalled");
endmodule
